/* rtl/wts_pkg.sv */
// Shared widths and register indexes for the wall texture sampler.
package wts_pkg;

  localparam int XY_W    = 12;
  localparam int FRAC_W  = 16;
  localparam int LH_W    = 16;
  localparam int LD_W    = 6;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 28;
  localparam int TEXI_W  = 6;
  localparam int DIM_W   = 7;
  localparam int LINE_W  = 16;
  localparam int BPP_W   = 3;
  localparam int PX_W    = XY_W + BPP_W;
  localparam int NUM_W   = XY_W + DIM_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIX  = 8'd3;

  localparam logic [LINE_W-1:0] LINE_BYTES_RST = 16'd4096;
  localparam logic [BPP_W-1:0]  BPP_RST        = 3'd4;

endpackage

/* rtl/wts_in_if.sv */
// Request channel: texel loads and pixel draws.
interface wts_in_if import wts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [XY_W-1:0]   screen_x;
  logic [XY_W-1:0]   screen_y;
  logic [FRAC_W-1:0] wall_frac;
  logic              hit_side;
  logic              ray_x_positive;
  logic              ray_y_negative;
  logic [LH_W-1:0]   line_height;
  logic [XY_W-1:0]   draw_start;
  logic [LD_W-1:0]   load_row;
  logic [LD_W-1:0]   load_col;
  logic [COLOR_W-1:0] load_value;

  modport source (
    output valid, req_type, screen_x, screen_y, wall_frac, hit_side, ray_x_positive,
           ray_y_negative, line_height, draw_start, load_row, load_col, load_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, screen_x, screen_y, wall_frac, hit_side, ray_x_positive,
           ray_y_negative, line_height, draw_start, load_row, load_col, load_value,
    output ready
  );
endinterface

/* rtl/wts_out_if.sv */
// Result channel: frame buffer pixel writes.
interface wts_out_if import wts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ADDR_W-1:0]  dst_addr;
  logic [COLOR_W-1:0] color;
  logic [TEXI_W-1:0]  tex_col;
  logic [TEXI_W-1:0]  tex_row;

  modport source (
    output valid, write_enable, dst_addr, color, tex_col, tex_row,
    input  ready
  );
  modport sink (
    input  valid, write_enable, dst_addr, color, tex_col, tex_row,
    output ready
  );
endinterface

/* rtl/wts_cfg_if.sv */
// Configuration write channel.
interface wts_cfg_if import wts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wts_ram.sv */
// Generic single write port RAM with registered read.
module wts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/wall_texture_sampler.sv */
// Wall texture sampler: texel store, column/row mapping and frame buffer addressing.
//
// Channels: req carries load items (req_type 0) that write one texel and draw items
// (req_type 1) that map one screen pixel of a wall slice to a texel. rsp returns one
// beat per request beat, in order; a load returns all-zero fields. cfg writes the
// texture size, line pitch and bytes per pixel; write it only while no item is in
// flight. cfg.ready is always high.
// Stages: a beat passes the input, prep, divide, row, memory and output stages in order.
// Throughput: one beat per cycle while rsp.ready is high. The row divide is a restoring
// divider with one quotient bit per stage (seven stages), and the texture store has one
// read and one write port, touched by each beat at most once as it passes the memory stage.
// Reset: the pipeline empties and the registers return to 64x64 texels, a pitch of
// 4096 bytes and 4 bytes per pixel. The texture store is not cleared: draw only
// texels that were loaded. No clearing pass is needed, so req.ready rises right
// after reset.
// Stall: when rsp.ready is low the result holds; earlier stages keep filling
// bubbles and req.ready drops only once every stage holds a beat.
module wall_texture_sampler import wts_pkg::*; #(
  parameter int TEX_DIM = 64
) (
  input logic        clk,
  input logic        rst,
  wts_in_if.sink     req,
  wts_out_if.source  rsp,
  wts_cfg_if.sink    cfg
);

  localparam int AW      = $clog2(TEX_DIM * TEX_DIM);
  localparam int DIM_MAX = (TEX_DIM < 128) ? TEX_DIM : 127;
  localparam int DIM_RST = (DIM_MAX < 64) ? DIM_MAX : 64;
  localparam int NS      = 12;
  localparam int S_IN    = 0;
  localparam int S_PREP  = 1;
  localparam int S_DIV0  = 2;
  localparam int S_DIVN  = 8;
  localparam int S_ROW   = 9;
  localparam int S_MEM   = 10;
  localparam int S_OUT   = 11;
  localparam int QB      = S_DIVN - S_DIV0 + 1;
  localparam int NB_W    = $clog2(NUM_W);

  typedef struct packed {
    logic               req;
    logic               mirror;
    logic               lh_zero;
    logic               below;
    logic               big;
    logic               load_ok;
    logic               px_we;
    logic [LH_W-1:0]    lh;
    logic [NUM_W-1:0]   num;
    logic [LH_W-1:0]    rem;
    logic [DIM_W-1:0]   q;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic [ADDR_W-1:0]  prod_y;
    logic [PX_W-1:0]    prod_x;
    logic [ADDR_W-1:0]  addr;
    logic [AW-1:0]      maddr;
    logic [LD_W-1:0]    lrow;
    logic [LD_W-1:0]    lcol;
    logic [COLOR_W-1:0] lval;
  } pipe_t;

  // Config registers, kept as effective (saturated) sizes
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [LINE_W-1:0] line_bytes;
  logic [BPP_W-1:0]  bpp;

  pipe_t           st   [NS];
  pipe_t           nxt  [NS];
  logic [NS-1:0]   v;
  logic [NS-1:0]   ld;
  logic [COLOR_W-1:0] ram_rdata;
  logic            ram_we;
  logic            ram_re;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] x);
    logic [DIM_W-1:0] r;
    r = x;
    if (x == '0) begin
      r = DIM_W'(1);
    end else if (x > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

  // One restoring step: bring in one numerator bit, subtract if it fits
  function automatic pipe_t div_step(input pipe_t s, input logic [NB_W-1:0] b);
    pipe_t            r;
    logic [LH_W:0]    sh;
    r  = s;
    sh = {s.rem, s.num[b]};
    if (sh >= {1'b0, s.lh}) begin
      r.rem = LH_W'(sh - {1'b0, s.lh});
      r.q   = {s.q[DIM_W-2:0], 1'b1};
    end else begin
      r.rem = sh[LH_W-1:0];
      r.q   = {s.q[DIM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff      <= DIM_W'(DIM_RST);
      h_eff      <= DIM_W'(DIM_RST);
      line_bytes <= LINE_BYTES_RST;
      bpp        <= BPP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TEX_WIDTH:     w_eff      <= sat_dim(cfg.data[DIM_W-1:0]);
        REG_TEX_HEIGHT:    h_eff      <= sat_dim(cfg.data[DIM_W-1:0]);
        REG_LINE_BYTES:    line_bytes <= cfg.data[LINE_W-1:0];
        REG_BYTES_PER_PIX: bpp        <= cfg.data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes a new beat when rsp.ready is high, when it is empty or when some later stage is empty
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      ld[i] = rsp.ready || ((v | NS'((1 << i) - 1)) != '1);
    end
  end

  assign req.ready = ld[S_IN];

  always_comb begin
    pipe_t            n;
    logic [FRAC_W+DIM_W-1:0] colprod;
    logic [XY_W-1:0]  diff;
    logic [DIM_W-1:0] row;

    // Input stage: products and flags
    n         = '0;
    colprod   = (FRAC_W+DIM_W)'(req.wall_frac) * (FRAC_W+DIM_W)'(w_eff);
    diff      = req.screen_y - req.draw_start;
    n.req     = req.req_type;
    n.mirror  = (!req.hit_side && req.ray_x_positive) || (req.hit_side && req.ray_y_negative);
    n.lh      = req.line_height;
    n.lh_zero = (req.line_height == '0);
    n.below   = (req.screen_y < req.draw_start);
    n.col     = colprod[FRAC_W +: DIM_W];
    n.num     = NUM_W'(diff) * NUM_W'(h_eff);
    n.prod_y  = ADDR_W'(req.screen_y) * ADDR_W'(line_bytes);
    n.prod_x  = PX_W'(req.screen_x) * PX_W'(bpp);
    n.load_ok = (int'(req.load_row) < TEX_DIM) && (int'(req.load_col) < TEX_DIM);
    n.lrow    = req.load_row;
    n.lcol    = req.load_col;
    n.lval    = req.load_value;
    nxt[S_IN] = n;

    // Mirror, address sum, divider setup
    n = st[S_IN];
    if (n.mirror) begin
      n.col = w_eff - DIM_W'(1) - n.col;
    end
    n.addr = n.prod_y + ADDR_W'(n.prod_x);
    n.big  = {{(LH_W-NUM_W+QB){1'b0}}, n.num[NUM_W-1:QB]} >= n.lh;
    n.rem  = LH_W'(n.num[NUM_W-1:QB]);
    n.q    = '0;
    nxt[S_PREP] = n;

    for (int i = S_DIV0; i <= S_DIVN; i++) begin
      nxt[i] = div_step(st[i-1], NB_W'(S_DIVN - i));
    end

    // Row select and store address
    n = st[S_DIVN];
    if (n.lh_zero) begin
      row = h_eff - DIM_W'(1);
    end else if (n.below) begin
      row = '0;
    end else if (n.big || n.q >= h_eff) begin
      row = h_eff - DIM_W'(1);
    end else begin
      row = n.q;
    end
    n.row = row;
    if (n.req) begin
      n.maddr = AW'(row) * AW'(TEX_DIM) + AW'(n.col);
    end else begin
      n.maddr = AW'(n.lrow) * AW'(TEX_DIM) + AW'(n.lcol);
    end
    nxt[S_ROW] = n;

    nxt[S_MEM] = st[S_ROW];

    // Result: loads return zeros
    n = st[S_MEM];
    if (n.req) begin
      n.lval  = ram_rdata;
      n.px_we = (ram_rdata != '0);
    end else begin
      n.lval  = '0;
      n.px_we = 1'b0;
      n.addr  = '0;
      n.col   = '0;
      n.row   = '0;
    end
    nxt[S_OUT] = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[S_IN]) begin
        v[S_IN] <= req.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ld[i]) begin
        st[i] <= nxt[i];
      end
    end
  end

  // Each beat touches the store at most once, as it moves into the memory stage
  assign ram_we = ld[S_MEM] && v[S_ROW] && !st[S_ROW].req && st[S_ROW].load_ok;
  assign ram_re = ld[S_MEM] && v[S_ROW] && st[S_ROW].req;

  wts_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TEX_DIM * TEX_DIM)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (st[S_ROW].maddr),
    .wdata (st[S_ROW].lval),
    .re    (ram_re),
    .raddr (st[S_ROW].maddr),
    .rdata (ram_rdata)
  );

  assign rsp.valid        = v[S_OUT];
  assign rsp.write_enable = st[S_OUT].px_we;
  assign rsp.dst_addr     = st[S_OUT].addr;
  assign rsp.color        = st[S_OUT].lval;
  assign rsp.tex_col      = st[S_OUT].col[TEXI_W-1:0];
  assign rsp.tex_row      = st[S_OUT].row[TEXI_W-1:0];

`ifndef SYNTHESIS
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v == '1))
    else $error("request stalled while a stage is empty");

  a_beat_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(v) == $past($countones(v))
      + int'($past(req.valid && req.ready)) - int'($past(rsp.valid && rsp.ready))))
    else $error("beat lost or duplicated in pipeline");

  a_draw_in_texture: assert property (@(posedge clk) disable iff (rst)
    (v[S_OUT] && st[S_OUT].req) |-> (st[S_OUT].row < h_eff && st[S_OUT].col < w_eff))
    else $error("texel index outside texture");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (v[S_OUT] && !st[S_OUT].req) |-> (!rsp.write_enable && rsp.color == '0
      && rsp.dst_addr == '0))
    else $error("load beat returned nonzero result");
`endif

endmodule

/* bench/wts_tb_pkg.sv */
// Request codes and texture geometry shared by the wall texture sampler bench files.
package wts_tb_pkg;
  import wts_pkg::*;

  localparam int TEX_DIM = 64;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;

endpackage

/* bench/wall_texture_sampler_checker.sv */
// Scoreboard for the wall texture sampler: predicts each pixel beat and checks the result channel.
module wall_texture_sampler_checker
  import wts_pkg::*;
  import wts_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wts_in_if    req,
  wts_out_if   rsp,
  wts_cfg_if   cfg,
  output int   pending,
  output int   fail_count
);

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [TEXI_W-1:0]  col;
    logic [TEXI_W-1:0]  row;
  } pixel_t;

  logic [COLOR_W-1:0] texels [TEX_DIM*TEX_DIM];
  logic [DIM_W-1:0]   tex_w;
  logic [DIM_W-1:0]   tex_h;
  logic [LINE_W-1:0]  pitch;
  logic [BPP_W-1:0]   bpp;
  pixel_t             pending_pixels [$];
  int                 errors = 0;

  // Saturate a size register to 1..TEX_DIM.
  function automatic int fit_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > TEX_DIM) return TEX_DIM;
    return int'(v);
  endfunction

  // Texture store slot (row * TEX_DIM + col) that a draw reads under the current registers.
  function automatic int texel_slot(logic [FRAC_W-1:0] frac, logic side, logic xpos,
                                    logic yneg, logic [LH_W-1:0] lh,
                                    logic [XY_W-1:0] sy, logic [XY_W-1:0] ds);
    int w;
    int h;
    int col;
    int row;
    w = fit_dim(tex_w);
    h = fit_dim(tex_h);
    col = (int'(frac) * w) / 65536;
    if (side ? yneg : xpos) col = w - 1 - col;
    if (lh == '0) begin
      row = h - 1;
    end else if (sy < ds) begin
      row = 0;
    end else begin
      row = (int'(sy - ds) * h) / int'(lh);
      if (row >= h) row = h - 1;
    end
    return row * TEX_DIM + col;
  endfunction

  always @(posedge clk) begin
    pixel_t      want;
    pixel_t      seen;
    int          slot;
    logic [31:0] addr_full;
    if (rst) begin
      tex_w = 7'd64;
      tex_h = 7'd64;
      pitch = LINE_BYTES_RST;
      bpp   = BPP_RST;
      pending_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TEX_WIDTH:     tex_w = cfg.data[DIM_W-1:0];
          REG_TEX_HEIGHT:    tex_h = cfg.data[DIM_W-1:0];
          REG_LINE_BYTES:    pitch = cfg.data[LINE_W-1:0];
          REG_BYTES_PER_PIX: bpp   = cfg.data[BPP_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.write_enable, rsp.dst_addr, rsp.color, rsp.tex_col, rsp.tex_row};
        if (pending_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: we=%0b addr=%h color=%h col=%0d row=%0d",
                     seen.we, seen.addr, seen.color, seen.col, seen.row);
        end else begin
          want = pending_pixels.pop_front();
          if (seen.we !== want.we || seen.addr !== want.addr || seen.color !== want.color ||
              seen.col !== want.col || seen.row !== want.row) begin
            errors++;
            if (errors <= 10) begin
              $display("pixel mismatch: want we=%0b addr=%h color=%h col=%0d row=%0d",
                       want.we, want.addr, want.color, want.col, want.row);
              $display("                got  we=%0b addr=%h color=%h col=%0d row=%0d",
                       seen.we, seen.addr, seen.color, seen.col, seen.row);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LOAD) begin
          texels[int'(req.load_row) * TEX_DIM + int'(req.load_col)] = req.load_value;
          want = '0;
        end else begin
          slot = texel_slot(req.wall_frac, req.hit_side, req.ray_x_positive,
                            req.ray_y_negative, req.line_height, req.screen_y,
                            req.draw_start);
          addr_full = 32'(req.screen_y) * 32'(pitch) + 32'(req.screen_x) * 32'(bpp);
          want.color = texels[slot];
          want.we    = (want.color != '0);
          want.addr  = addr_full[ADDR_W-1:0];
          want.col   = TEXI_W'(slot % TEX_DIM);
          want.row   = TEXI_W'(slot / TEX_DIM);
        end
        pending_pixels.push_back(want);
      end
    end
    pending    <= pending_pixels.size();
    fail_count <= errors;
  end

endmodule

/* bench/wall_texture_sampler_tb.sv */
// Top of the wall texture sampler bench: clock, reset, request and register stimulus, verdict.
module wall_texture_sampler_tb;
  import wts_pkg::*;
  import wts_tb_pkg::*;

  localparam int LATENCY        = 12;
  localparam int SQUEEZE_CYCLES = 120;
  localparam int PHASE_ITEMS    = 40;
  localparam int NUM_PHASES     = 8;

  typedef struct {
    logic               req_type;
    logic [XY_W-1:0]    sx;
    logic [XY_W-1:0]    sy;
    logic [FRAC_W-1:0]  frac;
    logic               side;
    logic               xpos;
    logic               yneg;
    logic [LH_W-1:0]    lh;
    logic [XY_W-1:0]    ds;
    logic [LD_W-1:0]    lrow;
    logic [LD_W-1:0]    lcol;
    logic [COLOR_W-1:0] lval;
  } tex_req_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic clk = 1'b0;
  logic rst;
  int   pending;
  int   fail_count;
  bit   squeeze_req = 1'b0;
  bit   gapless = 1'b0;
  int   burst_left = 0;
  int   n_loads = 0;
  int   n_draws = 0;
  int   n_fills = 0;
  bit   loaded [TEX_DIM*TEX_DIM];

  wts_in_if  req ();
  wts_out_if rsp ();
  wts_cfg_if cfg ();

  wall_texture_sampler #(.TEX_DIM(TEX_DIM)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  wall_texture_sampler_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #1 clk = ~clk;

  initial begin
    #800000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side stalls: random runs of modes, plus one long hold on request.
  initial begin : sink_pacer
    stall_mode_e mode;
    int          run_left;
    int          hold_left;
    mode = STALL_NONE;
    run_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = SQUEEZE_CYCLES - 1;
        rsp.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          run_left = $urandom_range(20, 200);
        end
        run_left--;
        case (mode)
          STALL_NONE:  rsp.ready <= 1'b1;
          STALL_LIGHT: rsp.ready <= ($urandom_range(0, 3) != 0);
          STALL_HALF:  rsp.ready <= 1'($urandom);
          default:     rsp.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic logic [COLOR_W-1:0] fresh_texel();
    return ($urandom_range(0, 7) == 0) ? '0 : COLOR_W'($urandom);
  endfunction

  // Random beat; the draw geometry is shaped so most rows land inside the slice.
  function automatic tex_req_t rand_item();
    tex_req_t it;
    int       span;
    it.req_type = ($urandom_range(0, 3) == 0) ? REQ_LOAD : REQ_DRAW;
    it.sx   = XY_W'($urandom);
    it.frac = FRAC_W'($urandom);
    it.side = 1'($urandom);
    it.xpos = 1'($urandom);
    it.yneg = 1'($urandom);
    it.lrow = LD_W'($urandom);
    it.lcol = LD_W'($urandom);
    it.lval = fresh_texel();
    case ($urandom_range(0, 9))
      0: begin
        it.lh = '0;
        it.sy = XY_W'($urandom);
        it.ds = XY_W'($urandom_range(0, it.sy));
      end
      1: begin
        it.lh = LH_W'($urandom);
        it.sy = XY_W'($urandom);
        it.ds = XY_W'($urandom_range(0, it.sy));
      end
      2: begin
        it.ds = XY_W'($urandom_range(1, 4095));
        it.sy = XY_W'($urandom_range(0, it.ds - 1));
        it.lh = LH_W'($urandom_range(1, 4096));
      end
      default: begin
        it.lh = LH_W'($urandom_range(1, 700));
        it.ds = XY_W'($urandom);
        span  = int'(it.ds) + int'($urandom_range(0, it.lh + it.lh / 4));
        it.sy = XY_W'((span > 4095) ? 4095 : span);
      end
    endcase
    return it;
  endfunction

  task automatic put_fields(input tex_req_t it);
    req.req_type       <= it.req_type;
    req.screen_x       <= it.sx;
    req.screen_y       <= it.sy;
    req.wall_frac      <= it.frac;
    req.hit_side       <= it.side;
    req.ray_x_positive <= it.xpos;
    req.ray_y_negative <= it.yneg;
    req.line_height    <= it.lh;
    req.draw_start     <= it.ds;
    req.load_row       <= it.lrow;
    req.load_col       <= it.lcol;
    req.load_value     <= it.lval;
  endtask

  task automatic send_item(input tex_req_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
      if (!gapless) begin
        gap = $urandom_range(1, 12);
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    put_fields(it);
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (it.req_type == REQ_LOAD) begin
      loaded[int'(it.lrow) * TEX_DIM + int'(it.lcol)] = 1'b1;
      n_loads++;
    end else begin
      n_draws++;
    end
  endtask

  // Load the texel a draw is about to read if nothing has been stored there yet.
  task automatic send_draw(input tex_req_t it);
    tex_req_t fill;
    int       slot;
    slot = u_check.texel_slot(it.frac, it.side, it.xpos, it.yneg, it.lh, it.sy, it.ds);
    if (!loaded[slot]) begin
      fill = rand_item();
      fill.req_type = REQ_LOAD;
      fill.lrow = LD_W'(slot / TEX_DIM);
      fill.lcol = LD_W'(slot % TEX_DIM);
      send_item(fill);
      n_fills++;
    end
    send_item(it);
  endtask

  task automatic load_at(input int row, input int col, input logic [COLOR_W-1:0] val);
    tex_req_t it;
    it = rand_item();
    it.req_type = REQ_LOAD;
    it.lrow = LD_W'(row);
    it.lcol = LD_W'(col);
    it.lval = val;
    send_item(it);
  endtask

  task automatic draw_at(input int sx, input int sy, input int frac, input logic side,
                         input logic xpos, input logic yneg, input int lh, input int ds);
    tex_req_t it;
    it = rand_item();
    it.req_type = REQ_DRAW;
    it.sx   = XY_W'(sx);
    it.sy   = XY_W'(sy);
    it.frac = FRAC_W'(frac);
    it.side = side;
    it.xpos = xpos;
    it.yneg = yneg;
    it.lh   = LH_W'(lh);
    it.ds   = XY_W'(ds);
    send_draw(it);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] pitch,
                              input logic [CFG_DATA_W-1:0] bpp, input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idxs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int                    i;
    idxs = '{REG_TEX_WIDTH, REG_TEX_HEIGHT, REG_LINE_BYTES, REG_BYTES_PER_PIX, REG_SPARE};
    vals = '{w, h, pitch, bpp, CFG_DATA_W'($urandom)};
    // Spare index goes last so a decode alias would clobber a live register.
    for (i = 0; i < (poke_spare ? 5 : 4); i++) begin
      cfg.index <= idxs[i];
      cfg.data  <= vals[i];
      cfg.valid <= 1'b1;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    tex_req_t it;
    int       k;
    for (k = 0; k < count; k++) begin
      it = rand_item();
      if (it.req_type == REQ_LOAD) send_item(it);
      else send_draw(it);
    end
  endtask

  initial begin : stimulus
    tex_req_t idle_item;
    int       p;
    idle_item = '{default: '0};
    rst <= 1'b1;
    req.valid <= 1'b0;
    put_fields(idle_item);
    cfg.valid <= 1'b0;
    cfg.index <= REG_TEX_WIDTH;
    cfg.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: 64x64 texture, 4096-byte pitch, 4 bytes per pixel.
    load_at(0, 0, '0);
    load_at(63, 63, 32'hFFFF_FFFF);
    load_at(0, 63, 32'h8000_0001);
    load_at(63, 0, 32'h7FFF_FFFE);
    draw_at(0, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0);                 // zero height: last row
    draw_at(17, 100, 16'hFFFF, 1'b0, 1'b0, 1'b1, 50, 100);   // top of slice, last column
    draw_at(5, 5, 0, 1'b0, 1'b1, 1'b0, 20, 10);               // x-side mirror, row above slice
    draw_at(1, 0, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1, 0);          // y-side mirror onto transparent
    draw_at(4095, 4095, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1, 0);    // no mirror, clamp, top address
    draw_at(2000, 4095, 0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 0);    // tallest slice
    draw_at(9, 163, 16'h8000, 1'b0, 1'b0, 1'b0, 64, 100);     // last row exactly
    draw_at(9, 164, 16'h8000, 1'b0, 1'b0, 1'b0, 64, 100);     // one row past: clamp
    load_at(63, 63, '0);
    draw_at(4095, 4095, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1, 0);    // same texel, now transparent
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(16'd1, 16'd1, 16'd0, 16'd0, 1'b1);
        1: program_regs(16'd64, 16'd64, 16'hFFFF, 16'd7, 1'b0);
        2: program_regs(16'd0, 16'd127, 16'd1, 16'd5, 1'b0);
        3: program_regs(16'd127, 16'd0, CFG_DATA_W'($urandom), 16'd6, 1'b0);
        4: program_regs(16'd64, 16'd64, 16'd4096, 16'd4, 1'b0);
        default: program_regs(
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64)),
          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64)),
          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 7)), p == NUM_PHASES - 1);
      endcase
      // Keep offering beats back to back while the result side holds off.
      if (p == 4) begin
        gapless = 1'b1;
        squeeze_req = 1'b1;
      end
      random_items(PHASE_ITEMS);
      gapless = 1'b0;
      drain();
    end

    repeat (4 * LATENCY) @(posedge clk);
    $display("Covered %0d texel loads (%0d placed ahead of draws) and %0d pixel draws",
             n_loads, n_fills, n_draws);
    $display("over %0d register settings, with a long result-side hold-off.", NUM_PHASES + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
